// ===== sv/arbitrary_block_deframer_macros.svh =====
// Assertion helpers used by the deframer top level.
`ifndef ARBITRARY_BLOCK_DEFRAMER_MACROS_SVH
`define ARBITRARY_BLOCK_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/abd_pkg.sv =====
`timescale 1ns / 1ps

package abd_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 30;

  // The result queue holds up to four words; a byte yields at most two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  typedef enum logic [2:0] {
    PH_HASH    = 3'd0,
    PH_COUNT   = 3'd1,
    PH_LEN     = 3'd2,
    PH_LEN_BAD = 3'd3,
    PH_DEF     = 3'd4,
    PH_INDEF   = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NO_HASH    = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_BAD_LEN    = 3'd4,
    ST_INCOMPLETE = 3'd5,
    ST_TRUNCATED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       end_of_result;
    status_t    status;
  } out_word_t;

  // Words handed from the parser to the queue for one accepted byte.
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  typedef struct packed {
    logic                room;
    logic [QLEVEL_W-1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } head_t;

endpackage

// ===== sv/abd_front.sv =====
`timescale 1ns / 1ps

module abd_front #(
  parameter int COUNT_WIDTH = abd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  abd_pkg::in_word_t in_data,
  input  logic              room,
  output abd_pkg::push_t    push
);

  localparam int EXT_W = COUNT_WIDTH + 4;

  abd_pkg::phase_t phase;
  abd_pkg::phase_t phase_next;
  logic [3:0]             digits_left;
  logic [3:0]             digits_left_next;
  logic [COUNT_WIDTH-1:0] length_count;
  logic [COUNT_WIDTH-1:0] length_count_next;
  logic [7:0]             held_byte;
  logic [7:0]             held_byte_next;
  logic                   held_valid;
  logic                   held_valid_next;

  logic                   fire;
  logic [7:0]             b;
  logic                   last;
  logic                   is_digit;
  logic [7:0]             diff;
  logic [3:0]             digit;
  abd_pkg::phase_t        after;
  logic [EXT_W-1:0]       len_ext;
  logic [EXT_W-1:0]       prod;
  logic                   ovf;
  logic                   len_bad;
  logic [COUNT_WIDTH-1:0] len_acc;
  logic [3:0]             dl_dec;
  logic [COUNT_WIDTH-1:0] len_dec;
  abd_pkg::push_t         res;

  assign fire     = in_valid && room;
  assign b        = in_data.in_byte;
  assign last     = in_data.block_end;
  assign is_digit = (b >= abd_pkg::CH_ZERO) && (b <= abd_pkg::CH_NINE);
  assign diff     = b - abd_pkg::CH_ZERO;
  assign digit    = diff[3:0];
  assign after    = last ? abd_pkg::PH_HASH : abd_pkg::PH_SKIP;

  // Decimal accumulate as length*8 + length*2 + digit; the top four bits flag overflow.
  assign len_ext = {4'b0, length_count};
  assign prod    = (len_ext << 3) + (len_ext << 1) + {{(EXT_W - 4){1'b0}}, digit};
  assign ovf     = |prod[EXT_W-1:COUNT_WIDTH];
  assign len_bad = (phase == abd_pkg::PH_LEN_BAD) || !is_digit || ovf;
  assign len_acc = ((phase == abd_pkg::PH_LEN) && is_digit && !ovf) ?
                   prod[COUNT_WIDTH-1:0] : length_count;
  assign dl_dec  = digits_left - 4'd1;
  assign len_dec = length_count - {{(COUNT_WIDTH - 1){1'b0}}, 1'b1};

  always_comb begin
    phase_next = phase;
    case (phase)
      abd_pkg::PH_HASH: begin
        if (b != abd_pkg::CH_HASH) begin
          phase_next = after;
        end else if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end else begin
          phase_next = abd_pkg::PH_COUNT;
        end
      end
      abd_pkg::PH_COUNT: begin
        if (!is_digit) begin
          phase_next = after;
        end else if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end else if (b == abd_pkg::CH_ZERO) begin
          phase_next = abd_pkg::PH_INDEF;
        end else begin
          phase_next = abd_pkg::PH_LEN;
        end
      end
      abd_pkg::PH_LEN, abd_pkg::PH_LEN_BAD: begin
        if (dl_dec == 4'd0) begin
          if (len_bad || (len_acc == '0)) begin
            phase_next = after;
          end else if (last) begin
            phase_next = abd_pkg::PH_HASH;
          end else begin
            phase_next = abd_pkg::PH_DEF;
          end
        end else if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end else begin
          phase_next = len_bad ? abd_pkg::PH_LEN_BAD : abd_pkg::PH_LEN;
        end
      end
      abd_pkg::PH_DEF: begin
        if (len_dec == '0) begin
          phase_next = after;
        end else if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end
      end
      abd_pkg::PH_INDEF: begin
        if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end
      end
      default: begin
        if (last) begin
          phase_next = abd_pkg::PH_HASH;
        end
      end
    endcase
  end

  always_comb begin
    digits_left_next  = digits_left;
    length_count_next = length_count;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    case (phase)
      abd_pkg::PH_COUNT: begin
        if (is_digit && (b == abd_pkg::CH_ZERO)) begin
          held_valid_next = 1'b0;
          held_byte_next  = '0;
        end else if (is_digit) begin
          digits_left_next  = digit;
          length_count_next = '0;
        end
      end
      abd_pkg::PH_LEN, abd_pkg::PH_LEN_BAD: begin
        digits_left_next  = dl_dec;
        length_count_next = len_acc;
      end
      abd_pkg::PH_DEF: begin
        length_count_next = len_dec;
      end
      abd_pkg::PH_INDEF: begin
        if (last) begin
          held_valid_next = 1'b0;
          held_byte_next  = '0;
        end else begin
          held_valid_next = 1'b1;
          held_byte_next  = b;
        end
      end
      default: begin
        digits_left_next = digits_left;
      end
    endcase
  end

  // Result words for the byte being accepted; the first word always goes in w0.
  always_comb begin
    res = '0;
    case (phase)
      abd_pkg::PH_HASH: begin
        if (b != abd_pkg::CH_HASH) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_NO_HASH};
        end else if (last) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_INCOMPLETE};
        end
      end
      abd_pkg::PH_COUNT: begin
        if (!is_digit) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_BAD_COUNT};
        end else if (last && (b == abd_pkg::CH_ZERO)) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_EMPTY};
        end else if (last) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_INCOMPLETE};
        end
      end
      abd_pkg::PH_LEN, abd_pkg::PH_LEN_BAD: begin
        if (dl_dec == 4'd0) begin
          if (len_bad) begin
            res.cnt = 2'd1;
            res.w0  = '{8'd0, 1'b1, abd_pkg::ST_BAD_LEN};
          end else if (len_acc == '0) begin
            res.cnt = 2'd1;
            res.w0  = '{8'd0, 1'b1, abd_pkg::ST_EMPTY};
          end else if (last) begin
            res.cnt = 2'd1;
            res.w0  = '{8'd0, 1'b1, abd_pkg::ST_TRUNCATED};
          end
        end else if (last) begin
          res.cnt = 2'd1;
          res.w0  = '{8'd0, 1'b1, abd_pkg::ST_INCOMPLETE};
        end
      end
      abd_pkg::PH_DEF: begin
        if (len_dec == '0) begin
          res.cnt = 2'd1;
          res.w0  = '{b, 1'b1, abd_pkg::ST_DATA};
        end else begin
          res.cnt = last ? 2'd2 : 2'd1;
          res.w0  = '{b, 1'b0, abd_pkg::ST_DATA};
          res.w1  = '{8'd0, 1'b1, abd_pkg::ST_TRUNCATED};
        end
      end
      abd_pkg::PH_INDEF: begin
        if (!last) begin
          res.cnt = held_valid ? 2'd1 : 2'd0;
          res.w0  = '{held_byte, 1'b0, abd_pkg::ST_DATA};
        end else if (b == abd_pkg::CH_NEWLINE) begin
          res.cnt = 2'd1;
          if (held_valid) begin
            res.w0 = '{held_byte, 1'b1, abd_pkg::ST_DATA};
          end else begin
            res.w0 = '{8'd0, 1'b1, abd_pkg::ST_EMPTY};
          end
        end else if (held_valid) begin
          res.cnt = 2'd2;
          res.w0  = '{held_byte, 1'b0, abd_pkg::ST_DATA};
          res.w1  = '{b, 1'b1, abd_pkg::ST_DATA};
        end else begin
          res.cnt = 2'd1;
          res.w0  = '{b, 1'b1, abd_pkg::ST_DATA};
        end
      end
      default: begin
        res.cnt = 2'd0;
      end
    endcase
  end

  always_comb begin
    push     = res;
    push.cnt = fire ? res.cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= abd_pkg::PH_HASH;
      digits_left  <= '0;
      length_count <= '0;
      held_valid   <= 1'b0;
      held_byte    <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      digits_left  <= digits_left_next;
      length_count <= length_count_next;
      held_valid   <= held_valid_next;
      held_byte    <= held_byte_next;
    end
  end

endmodule

// ===== sv/abd_queue.sv =====
`timescale 1ns / 1ps

module abd_queue (
  input  logic             clk,
  input  logic             rst,
  input  abd_pkg::push_t   push,
  input  logic             pop,
  output abd_pkg::head_t   head,
  output abd_pkg::q_stat_t stat
);

  abd_pkg::out_word_t mem [abd_pkg::QUEUE_DEPTH];
  logic [abd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [abd_pkg::QPTR_W-1:0]   wr_ptr_next;
  logic [abd_pkg::QPTR_W-1:0]   wr_ptr_plus;
  logic [abd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [abd_pkg::QPTR_W-1:0]   rd_ptr_next;
  logic [abd_pkg::QLEVEL_W-1:0] level;
  logic [abd_pkg::QLEVEL_W-1:0] level_next;

  assign wr_ptr_plus = wr_ptr + {{(abd_pkg::QPTR_W - 1){1'b0}}, 1'b1};
  assign wr_ptr_next = wr_ptr + abd_pkg::QPTR_W'(push.cnt);
  assign rd_ptr_next = rd_ptr + abd_pkg::QPTR_W'(pop);
  assign level_next  = level + abd_pkg::QLEVEL_W'(push.cnt) - abd_pkg::QLEVEL_W'(pop);

  assign head.valid = (level != '0);
  assign head.word  = mem[rd_ptr];

  // Room is judged on the registered level so that a two-word byte always fits.
  assign stat.room  = (level <= abd_pkg::QLEVEL_W'(abd_pkg::QUEUE_DEPTH - 2));
  assign stat.level = level;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_plus] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

endmodule

// ===== sv/abd_back.sv =====
`timescale 1ns / 1ps

module abd_back (
  input  logic               clk,
  input  logic               rst,
  input  abd_pkg::head_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output abd_pkg::out_word_t out_data
);

  logic load;

  // The output register refills whenever it is empty or its word is being taken.
  assign load = !out_valid || out_ready;
  assign pop  = head.valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head.word;
    end
  end

endmodule

// ===== sv/arbitrary_block_deframer.sv =====
`timescale 1ns / 1ps

// Parses IEEE 488.2 arbitrary blocks: one byte per word in, block_end on the last
// byte, and payload bytes or a status word out. A byte is taken every cycle as long
// as the four-word result queue has two free entries; results pass from the parser
// into the queue, then from the queue into the output register. A byte that yields
// two words (truncation, or an indefinite block ending in a byte that is not a
// newline) leaves the queue one extra word to drain, so the sustained rate stays
// one byte per cycle while the output side keeps taking words.
// Streamed bytes of a truncated block are followed by a truncation status and
// must be discarded by the consumer.

`include "arbitrary_block_deframer_macros.svh"

module arbitrary_block_deframer #(
  parameter int COUNT_WIDTH = abd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  abd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output abd_pkg::out_word_t out_data
);

  abd_pkg::push_t   push;
  abd_pkg::head_t   head;
  abd_pkg::q_stat_t stat;
  logic             pop;

  assign in_ready = stat.room;

  abd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_data (in_data),
    .room    (stat.room),
    .push    (push)
  );

  abd_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (pop),
    .head(head),
    .stat(stat)
  );

  abd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `ABD_ASSERT_SAME(a_no_push_without_room, push.cnt != 2'd0, stat.room, "push while queue full")
  `ABD_ASSERT_SAME(a_push_count_legal, 1'b1, push.cnt != 2'd3, "more than two words per byte")
  `ABD_ASSERT_SAME(a_level_bounded, 1'b1, stat.level <= abd_pkg::QLEVEL_W'(abd_pkg::QUEUE_DEPTH), "queue level above depth")
  `ABD_ASSERT_NEXT(a_pop_loads_output, pop, out_valid, "popped word not presented")

endmodule
